// File: hdl/afc_pkg.sv
package afc_pkg;

  // fixed-point constants
  localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;  // 2*pi
  localparam logic [22:0] STALL_Q24   = 23'd4099447;    // 14 deg
  localparam logic [18:0] CD0_Q24     = 19'd335544;     // 0.02
  localparam logic [24:0] ONE_Q24     = 25'd16777216;
  localparam logic [17:0] KIND_Q16    = 18'd185301;     // pi*0.9
  localparam logic [20:0] SIGK_Q16    = 21'd1805743;    // log2(e)/(3 deg)
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // series lengths and divider widths
  localparam int TRIG_TERMS = 14;
  localparam int POW_TERMS  = 9;
  localparam int SIGM_QBITS = 17;
  localparam int DRAG_QBITS = 41;

  // unit latencies in register stages
  localparam int LAT_TRIG = 2 + 3 * TRIG_TERMS;
  localparam int LAT_SIGM = 6 + 3 * POW_TERMS + SIGM_QBITS;
  localparam int LAT_DRAG = 5 + DRAG_QBITS;
  localparam int LAT_CORE = LAT_SIGM;
  localparam int TRIG_PAD = LAT_CORE - LAT_TRIG;
  localparam int DRAG_PAD = LAT_CORE - LAT_DRAG;

  // rounded arithmetic right shift, half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -signed'(m) : signed'(m);
  endfunction

endpackage

// File: hdl/afc_trig.sv
module afc_trig
  import afc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [25:0] lift_plate,
  output logic        [25:0] drag_plate
);

  localparam int N = TRIG_TERMS;
  localparam logic [33:0] HP1 = 34'(HALF_PI_Q30);
  localparam logic [33:0] HP2 = HP1 + HP1;
  localparam logic [33:0] HP3 = HP2 + HP1;
  localparam logic [33:0] HP4 = HP3 + HP1;
  localparam logic [33:0] HP5 = HP4 + HP1;

  logic signed [16:0] ax;
  logic        [16:0] mag;
  logic        [33:0] b;
  logic        [2:0]  q_c;
  logic        [33:0] r_c;

  // state after each series term
  logic        [30:0] t_st [0:N];
  logic signed [32:0] s_st [0:N];
  logic signed [32:0] c_st [0:N];
  logic        [30:0] r_st [0:N];
  logic        [2:0]  q_st [0:N];
  logic               n_st [0:N];

  // quadrant reduction of |2a|
  always_comb begin
    ax  = 17'(angle);
    mag = ax[16] ? 17'(-ax) : 17'(ax);
    b   = 34'(mag) << 18;
    priority if (b >= HP5) begin
      q_c = 3'd5;
      r_c = b - HP5;
    end else if (b >= HP4) begin
      q_c = 3'd4;
      r_c = b - HP4;
    end else if (b >= HP3) begin
      q_c = 3'd3;
      r_c = b - HP3;
    end else if (b >= HP2) begin
      q_c = 3'd2;
      r_c = b - HP2;
    end else if (b >= HP1) begin
      q_c = 3'd1;
      r_c = b - HP1;
    end else begin
      q_c = 3'd0;
      r_c = b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_st[0] <= ONE_Q30;
      s_st[0] <= '0;
      c_st[0] <= signed'(33'(ONE_Q30));
      r_st[0] <= r_c[30:0];
      q_st[0] <= q_c;
      n_st[0] <= angle[15];
    end
  end

  // one taylor term per three stages: multiply, reciprocal, correct
  for (genvar k = 1; k <= N; k++) begin : g_term
    localparam int K = k;
    localparam int PH = K % 4;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
    localparam logic [61:0] RND = 62'(K) << 29;

    logic        [61:0] prod;
    logic signed [32:0] s_m, c_m, s_r, c_r;
    logic        [30:0] r_m, r_r;
    logic        [2:0]  q_m, q_r;
    logic               n_m, n_r;
    logic        [31:0] v_c, v_r;
    logic        [63:0] p_r;
    logic        [31:0] q0, rem, qf;
    logic signed [32:0] ts, s_new, c_new;

    always_comb begin
      v_c   = 32'((prod + RND) >> 30);
      q0    = p_r[63:32];
      rem   = v_r - 32'(36'(q0) * 36'(K));
      qf    = (rem >= 32'(K)) ? q0 + 32'd1 : q0;
      ts    = signed'({2'b00, qf[30:0]});
      s_new = s_r;
      c_new = c_r;
      unique case (PH)
        0:       c_new = c_r + ts;
        1:       s_new = s_r + ts;
        2:       c_new = c_r - ts;
        default: s_new = s_r - ts;
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod    <= 62'(t_st[k-1]) * 62'(r_st[k-1]);
        s_m     <= s_st[k-1];
        c_m     <= c_st[k-1];
        r_m     <= r_st[k-1];
        q_m     <= q_st[k-1];
        n_m     <= n_st[k-1];
        v_r     <= v_c;
        p_r     <= 64'(v_c) * 64'(RECIP);
        s_r     <= s_m;
        c_r     <= c_m;
        r_r     <= r_m;
        q_r     <= q_m;
        n_r     <= n_m;
        t_st[k] <= qf[30:0];
        s_st[k] <= s_new;
        c_st[k] <= c_new;
        r_st[k] <= r_r;
        q_st[k] <= q_r;
        n_st[k] <= n_r;
      end
    end
  end

  logic signed [32:0] rs, rc, sn;

  // quadrant symmetry and sign
  always_comb begin
    unique case (q_st[N][1:0])
      2'd0: begin
        rs = s_st[N];
        rc = c_st[N];
      end
      2'd1: begin
        rs = c_st[N];
        rc = -s_st[N];
      end
      2'd2: begin
        rs = -s_st[N];
        rc = -c_st[N];
      end
      default: begin
        rs = -c_st[N];
        rc = s_st[N];
      end
    endcase
    sn = n_st[N] ? -rs : rs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lift_plate <= 26'(rshr(64'(sn), 6));
      drag_plate <= 26'(64'(CD0_Q24) + 64'(ONE_Q24) - rshr(64'(rc), 6));
    end
  end

endmodule

// File: hdl/afc_sigm.sv
module afc_sigm
  import afc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic        [16:0] weight
);

  localparam int N = POW_TERMS;
  localparam int Q = SIGM_QBITS;

  logic signed [16:0] ax;
  logic        [16:0] mag;
  logic        [26:0] absa;
  logic        [26:0] dm_c;
  logic        [26:0] dm0;
  logic               neg0, neg1, neg2;
  logic        [47:0] prod1;
  logic        [31:0] u;
  logic        [53:0] gprod;
  logic        [7:0]  n2;

  logic        [30:0] t_st  [0:N];
  logic signed [31:0] sm_st [0:N];
  logic        [29:0] g_st  [0:N];
  logic        [7:0]  n_st  [0:N];
  logic               ng_st [0:N];

  // distance from the stall angle
  always_comb begin
    ax   = 17'(angle);
    mag  = ax[16] ? 17'(-ax) : 17'(ax);
    absa = 27'(mag) << 11;
    dm_c = (absa < 27'(STALL_Q24)) ? 27'(STALL_Q24) - absa : absa - 27'(STALL_Q24);
    u    = 32'((prod1 + 48'd32768) >> 16);
  end

  // scale, split exponent, fractional log
  always_ff @(posedge clk) begin
    if (en) begin
      dm0      <= dm_c;
      neg0     <= absa < 27'(STALL_Q24);
      prod1    <= 48'(dm0) * 48'(SIGK_Q16);
      neg1     <= neg0;
      gprod    <= 54'(u[23:0]) * 54'(LN2_Q30);
      n2       <= u[31:24];
      neg2     <= neg1;
      g_st[0]  <= 30'((gprod + 54'd8388608) >> 24);
      n_st[0]  <= n2;
      ng_st[0] <= neg2;
      t_st[0]  <= ONE_Q30;
      sm_st[0] <= signed'(32'(ONE_Q30));
    end
  end

  // exp(-g) series, three stages a term
  for (genvar k = 1; k <= N; k++) begin : g_term
    localparam int K = k;
    localparam int PH = K % 2;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
    localparam logic [60:0] RND = 61'(K) << 29;

    logic        [60:0] prod;
    logic signed [31:0] sm_m, sm_r;
    logic        [29:0] g_m, g_r;
    logic        [7:0]  n_m, n_r;
    logic               ng_m, ng_r;
    logic        [31:0] v_c, v_r;
    logic        [63:0] p_r;
    logic        [31:0] q0, rem, qf;
    logic signed [31:0] ts, sm_new;

    always_comb begin
      v_c  = 32'((prod + RND) >> 30);
      q0   = p_r[63:32];
      rem  = v_r - 32'(36'(q0) * 36'(K));
      qf   = (rem >= 32'(K)) ? q0 + 32'd1 : q0;
      ts   = signed'({1'b0, qf[30:0]});
      sm_new = (PH == 1) ? sm_r - ts : sm_r + ts;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod     <= 61'(t_st[k-1]) * 61'(g_st[k-1]);
        sm_m     <= sm_st[k-1];
        g_m      <= g_st[k-1];
        n_m      <= n_st[k-1];
        ng_m     <= ng_st[k-1];
        v_r      <= v_c;
        p_r      <= 64'(v_c) * 64'(RECIP);
        sm_r     <= sm_m;
        g_r      <= g_m;
        n_r      <= n_m;
        ng_r     <= ng_m;
        t_st[k]  <= qf[30:0];
        sm_st[k] <= sm_new;
        g_st[k]  <= g_r;
        n_st[k]  <= n_r;
        ng_st[k] <= ng_r;
      end
    end
  end

  logic [30:0] sc;
  logic [30:0] e;
  logic [31:0] dd;
  logic [46:0] num;

  // integer power shift and divider operands
  always_comb begin
    if (sm_st[N][31]) begin
      sc = '0;
    end else if (sm_st[N] > signed'(32'(ONE_Q30))) begin
      sc = ONE_Q30;
    end else begin
      sc = sm_st[N][30:0];
    end
    if (n_st[N] >= 8'd31) begin
      e = '0;
    end else if (n_st[N] == 8'd0) begin
      e = sc;
    end else begin
      e = 31'((32'(sc) + (32'd1 << (n_st[N][4:0] - 5'd1))) >> n_st[N][4:0]);
    end
    dd  = 32'(ONE_Q30) + 32'(e);
    num = (47'd1 << 46) + 47'(dd >> 1);
  end

  logic [30:0] dv_rem [0:Q];
  logic [Q-1:0] dv_nl [0:Q];
  logic [Q-1:0] dv_quo [0:Q];
  logic [31:0] dv_dd  [0:Q];
  logic        dv_ng  [0:Q];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= 31'(num[46:Q]);
      dv_nl[0]  <= num[Q-1:0];
      dv_quo[0] <= '0;
      dv_dd[0]  <= dd;
      dv_ng[0]  <= ng_st[N];
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar i = 0; i < Q; i++) begin : g_div
    logic [31:0] rs;
    logic        ge;

    always_comb begin
      rs = {dv_rem[i], dv_nl[i][Q-1]};
      ge = rs >= dv_dd[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[i+1] <= ge ? 31'(rs - dv_dd[i]) : 31'(rs);
        dv_nl[i+1]  <= dv_nl[i] << 1;
        dv_quo[i+1] <= {dv_quo[i][Q-2:0], ge};
        dv_dd[i+1]  <= dv_dd[i];
        dv_ng[i+1]  <= dv_ng[i];
      end
    end
  end

  // mirror below the stall angle
  always_ff @(posedge clk) begin
    if (en) begin
      weight <= dv_ng[Q] ? 17'd65536 - dv_quo[Q] : dv_quo[Q];
    end
  end

endmodule

// File: hdl/afc_drag.sv
module afc_drag
  import afc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  input  logic        [15:0] aspect_ratio,
  output logic signed [29:0] lift_attach,
  output logic        [40:0] drag_attach
);

  localparam int Q = DRAG_QBITS;

  logic signed [42:0] lprod;
  logic signed [29:0] ll_c, ll1, ll2, ll3;
  logic        [28:0] lmag;
  logic        [57:0] sq;
  logic        [33:0] den2;
  logic        [15:0] ar_eff;
  logic        [57:0] num;

  always_comb begin
    ll_c   = 30'(rshr(64'(lprod), 13));
    ar_eff = (aspect_ratio == 16'd0) ? 16'd1 : aspect_ratio;
    num    = sq + 58'(den2 >> 1);
  end

  logic [33:0]  dv_rem [0:Q];
  logic [Q-1:0] dv_nl  [0:Q];
  logic [Q-1:0] dv_quo [0:Q];
  logic [33:0]  dv_den [0:Q];
  logic signed [29:0] dv_ll [0:Q];

  // linear lift, its square and the induced drag divisor
  always_ff @(posedge clk) begin
    if (en) begin
      lprod     <= 43'(angle) * 43'(signed'({1'b0, TWO_PI_Q24}));
      ll1       <= ll_c;
      lmag      <= ll_c[29] ? 29'(-ll_c) : 29'(ll_c);
      sq        <= 58'(lmag) * 58'(lmag);
      den2      <= 34'(KIND_Q16) * 34'(ar_eff);
      ll2       <= ll1;
      dv_rem[0] <= 34'(num[57:Q]);
      dv_nl[0]  <= num[Q-1:0];
      dv_quo[0] <= '0;
      dv_den[0] <= den2;
      dv_ll[0]  <= ll2;
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar i = 0; i < Q; i++) begin : g_div
    logic [34:0] rs;
    logic        ge;

    always_comb begin
      rs = {dv_rem[i], dv_nl[i][Q-1]};
      ge = rs >= 35'(dv_den[i]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[i+1] <= ge ? 34'(rs - 35'(dv_den[i])) : 34'(rs);
        dv_nl[i+1]  <= dv_nl[i] << 1;
        dv_quo[i+1] <= {dv_quo[i][Q-2:0], ge};
        dv_den[i+1] <= dv_den[i];
        dv_ll[i+1]  <= dv_ll[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll3         <= dv_ll[Q];
      drag_attach <= 41'(CD0_Q24) + dv_quo[Q];
    end
  end

  assign lift_attach = ll3;

endmodule

// File: hdl/airfoil_lift_drag_coefficients_core.sv
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------
// input    | in_valid / in_ready     | attack_angle (s16, Q3.13 rad)
// output   | out_valid / out_ready   | lift_coefficient (s16), drag_coefficient (u15)
// config   | cfg_we                  | cfg_wdata -> aspect_ratio (u16, Q8.8)
//
// one transaction per cycle while not stalled; latency from acceptance to out_valid
// is set by the sigmoid unit (exp series, 17-stage divider) plus the blend stages.
// synchronous active-high reset clears the valid pipeline and sets aspect_ratio to 1.0.
// a stall at the output freezes the whole pipeline; in_ready drops with it.
module airfoil_lift_drag_coefficients_core
  import afc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] attack_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] lift_coefficient,
  output logic        [14:0] drag_coefficient,
  input  logic               cfg_we,
  input  logic        [15:0] cfg_wdata
);

  localparam int VLD_LEN = LAT_CORE + 4;

  logic                en;
  logic [VLD_LEN-1:0]  vld_pipe;
  logic signed [15:0]  a_reg;
  logic [15:0]         aspect_ratio;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_pipe[VLD_LEN-1];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_ratio <= 16'd256;
    end else if (cfg_we) begin
      aspect_ratio <= cfg_wdata;
    end
  end

  // valid bits and input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (en) begin
      vld_pipe <= {vld_pipe[VLD_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_reg <= attack_angle;
    end
  end

  logic signed [25:0] ls_u;
  logic        [25:0] ds_u;
  logic        [16:0] w_al;
  logic signed [29:0] ll_u;
  logic        [40:0] dl_u;

  afc_trig u_trig (
    .clk        (clk),
    .en         (en),
    .angle      (a_reg),
    .lift_plate (ls_u),
    .drag_plate (ds_u)
  );

  afc_sigm u_sigm (
    .clk    (clk),
    .en     (en),
    .angle  (a_reg),
    .weight (w_al)
  );

  afc_drag u_drag (
    .clk          (clk),
    .en           (en),
    .angle        (a_reg),
    .aspect_ratio (aspect_ratio),
    .lift_attach  (ll_u),
    .drag_attach  (dl_u)
  );

  // align the shorter units to the sigmoid
  logic signed [25:0] ls_pad [TRIG_PAD];
  logic        [25:0] ds_pad [TRIG_PAD];
  logic signed [29:0] ll_pad [DRAG_PAD];
  logic        [40:0] dl_pad [DRAG_PAD];

  always_ff @(posedge clk) begin
    if (en) begin
      ls_pad[0] <= ls_u;
      ds_pad[0] <= ds_u;
      for (int i = 1; i < TRIG_PAD; i++) begin
        ls_pad[i] <= ls_pad[i-1];
        ds_pad[i] <= ds_pad[i-1];
      end
      ll_pad[0] <= ll_u;
      dl_pad[0] <= dl_u;
      for (int j = 1; j < DRAG_PAD; j++) begin
        ll_pad[j] <= ll_pad[j-1];
        dl_pad[j] <= dl_pad[j-1];
      end
    end
  end

  logic signed [25:0] ls_al;
  logic        [25:0] ds_al;
  logic signed [29:0] ll_al;
  logic        [40:0] dl_al;
  logic        [16:0] wc;

  assign ls_al = ls_pad[TRIG_PAD-1];
  assign ds_al = ds_pad[TRIG_PAD-1];
  assign ll_al = ll_pad[DRAG_PAD-1];
  assign dl_al = dl_pad[DRAG_PAD-1];
  assign wc    = 17'd65536 - w_al;

  // blend: partial products, then sums
  logic signed [46:0] pl1;
  logic signed [42:0] pl2;
  logic        [40:0] pdl;
  logic        [33:0] pdh;
  logic        [42:0] pd2;
  logic signed [47:0] cl_sum;
  logic        [58:0] cd_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pl1    <= 47'(signed'({1'b0, wc})) * 47'(ll_al);
      pl2    <= 43'(signed'({1'b0, w_al})) * 43'(ls_al);
      pdl    <= 41'(wc) * 41'(dl_al[23:0]);
      pdh    <= 34'(wc) * 34'(dl_al[40:24]);
      pd2    <= 43'(w_al) * 43'(ds_al);
      cl_sum <= 48'(pl1) + 48'(pl2);
      cd_sum <= (59'(pdh) << 24) + 59'(pdl) + 59'(pd2);
    end
  end

  // round and saturate into the output register
  logic signed [63:0] cl_r;
  logic        [58:0] cd_r;

  always_comb begin
    cl_r = rshr(64'(cl_sum), 28);
    cd_r = (cd_sum + 59'd134217728) >> 28;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cl_r > 64'sd32767) begin
        lift_coefficient <= 16'sh7fff;
      end else if (cl_r < -64'sd32768) begin
        lift_coefficient <= -16'sh8000;
      end else begin
        lift_coefficient <= 16'(cl_r);
      end
      drag_coefficient <= (cd_r > 59'd32767) ? 15'h7fff : 15'(cd_r);
    end
  end

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_pipe))
    else $error("valid pipeline moved during a stall");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    vld_pipe[LAT_CORE] |-> (w_al <= 17'd65536))
    else $error("blend weight out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
